/* src/ptjlg_pkg.sv */
// Shared types, widths, register indexes and helpers for the pan/tilt limit guard.
package ptjlg_pkg;

   localparam int DATA_W   = 24;                 // signed Q8.16 speeds and positions
   localparam int LIMIT_W  = 23;                 // unsigned limits
   localparam int PROD_W   = DATA_W + LIMIT_W - 1; // |v| <= 2^23 times limit < 2^23
   localparam int QUO_W    = LIMIT_W;            // quotient never exceeds speed_limit
   localparam int REM_W    = DATA_W;             // remainder stays below divisor <= 2^23
   localparam int CNT_W    = $clog2(QUO_W + 1);
   localparam int CSR_AW   = 2;

   localparam logic [CSR_AW-1:0] CSR_PAN_SOFT_LIMIT  = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_TILT_SOFT_LIMIT = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_SPEED_LIMIT     = 2'd2;

   localparam logic [LIMIT_W-1:0] PAN_SOFT_LIMIT_RST  = 23'd196608;
   localparam logic [LIMIT_W-1:0] TILT_SOFT_LIMIT_RST = 23'd98304;
   localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST     = 23'd65536;

   // Request kinds carried on req_func.
   localparam logic FUNC_COMMAND = 1'b0;
   localparam logic FUNC_TICK    = 1'b1;

   // Sequencing strobes from the top level to each axis lane.
   typedef struct packed {
      logic prep;      // form |v| * speed_limit and load the divider
      logic step;      // one restoring division step
      logic commit;    // update lane state for the current transaction
      logic tick;      // current transaction is a control tick
      logic div_zero;  // divisor is zero, stored speed is forced to zero
   } lane_ctrl_type;

   // What one lane reports for the current transaction.
   typedef struct packed {
      logic signed [DATA_W-1:0] drive;
      logic                     send;
      logic                     at_limit;
      logic                     status;
   } lane_res_type;

   // Magnitude of a signed value; the most negative value maps to 2^23.
   function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] v);
      logic [DATA_W-1:0] r;
      r = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
      return r;
   endfunction

endpackage

/* src/ptjlg_div.sv */
// Restoring divider that produces one quotient bit per step.
module ptjlg_div (
   input  logic                           clock,
   input  logic                           load,
   input  logic                           step,
   input  logic [ptjlg_pkg::PROD_W-1:0]   dividend,
   input  logic [ptjlg_pkg::DATA_W-1:0]   divisor,
   output logic [ptjlg_pkg::QUO_W-1:0]    quotient
);
   import ptjlg_pkg::*;

   logic [REM_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] low_ff, low_in;
   logic [REM_W+1:0] diff;

   // The high half of the dividend is already below the divisor because the
   // quotient fits in QUO_W bits, so only QUO_W steps are needed.
   always_comb begin
      diff   = {1'b0, rem_ff, low_ff[QUO_W-1]} - {2'b00, divisor};
      rem_in = rem_ff;
      low_in = low_ff;
      if (load) begin
         rem_in = REM_W'(dividend[PROD_W-1:QUO_W]);
         low_in = dividend[QUO_W-1:0];
      end else if (step) begin
         if (!diff[REM_W+1]) begin
            rem_in = diff[REM_W-1:0];
         end else begin
            rem_in = {rem_ff[REM_W-2:0], low_ff[QUO_W-1]};
         end
         low_in = {low_ff[QUO_W-2:0], ~diff[REM_W+1]};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
   end

   assign quotient = low_ff;

endmodule

/* src/ptjlg_lane.sv */
// One axis lane: command scaling, soft limit test, decision tree and axis state.
module ptjlg_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  ptjlg_pkg::lane_ctrl_type            ctrl,
   input  logic signed [ptjlg_pkg::DATA_W-1:0] value,
   input  logic [ptjlg_pkg::LIMIT_W-1:0]       soft_limit,
   input  logic [ptjlg_pkg::LIMIT_W-1:0]       speed_limit,
   input  logic [ptjlg_pkg::DATA_W-1:0]        divisor,
   output ptjlg_pkg::lane_res_type             res
);
   import ptjlg_pkg::*;

   logic signed [DATA_W-1:0] desired_ff, desired_in;
   logic signed [DATA_W-1:0] prev_ff, prev_in;
   logic signed [DATA_W-1:0] drive_ff, drive_in;
   logic                     halt_ff, halt_in;
   logic                     len_ff, len_in;
   logic                     neg_ff;

   logic [DATA_W+LIMIT_W-1:0] product;
   logic [QUO_W-1:0]          quotient;
   logic [DATA_W-1:0]         q_ext;
   logic signed [DATA_W:0]    pos_ext, soft_ext;
   logic                      at_limit, is_new, rev, d_pos, d_neg, p_pos, p_neg;
   logic                      status, send;

   assign product = mag(value) * speed_limit;

   ptjlg_div u_div (
      .clock    (clock),
      .load     (ctrl.prep),
      .step     (ctrl.step),
      .dividend (product[PROD_W-1:0]),
      .divisor  (divisor),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (ctrl.prep) begin
         neg_ff <= value[DATA_W-1];
      end
   end

   assign q_ext    = ctrl.div_zero ? '0 : DATA_W'(quotient);
   assign pos_ext  = {value[DATA_W-1], value};
   assign soft_ext = $signed({2'b00, soft_limit});
   assign at_limit = (pos_ext < -soft_ext) || (pos_ext > soft_ext);

   assign d_pos  = !desired_ff[DATA_W-1] && (desired_ff != '0);
   assign d_neg  = desired_ff[DATA_W-1];
   assign p_pos  = !prev_ff[DATA_W-1] && (prev_ff != '0);
   assign p_neg  = prev_ff[DATA_W-1];
   assign is_new = desired_ff != prev_ff;
   assign rev    = (d_pos && p_neg) || (d_neg && p_pos);

   // Decision tree evaluated against the state left by earlier transactions.
   always_comb begin
      drive_in = drive_ff;
      halt_in  = halt_ff;
      len_in   = len_ff;
      status   = !at_limit;
      send     = 1'b0;
      if (is_new) begin
         if (at_limit) begin
            if (!rev) begin
               if (len_ff) begin
                  if (!halt_ff) begin
                     drive_in = '0;
                     halt_in  = 1'b1;
                     send     = 1'b1;
                  end
               end else begin
                  drive_in = desired_ff;
                  status   = 1'b1;
                  halt_in  = 1'b0;
                  send     = 1'b1;
               end
            end else if (len_ff) begin
               drive_in = desired_ff;
               status   = 1'b1;
               halt_in  = 1'b0;
               len_in   = 1'b0;
               send     = 1'b1;
            end else if (!halt_ff) begin
               drive_in = '0;
               halt_in  = 1'b1;
               len_in   = 1'b1;
               send     = 1'b1;
            end
         end else begin
            drive_in = desired_ff;
            status   = 1'b1;
            len_in   = 1'b1;
            send     = 1'b1;
         end
      end else if (at_limit) begin
         if (len_ff && !halt_ff) begin
            drive_in = '0;
            halt_in  = 1'b1;
            send     = 1'b1;
         end
      end else begin
         len_in = 1'b1;
      end
   end

   assign desired_in = neg_ff ? -$signed(q_ext) : $signed(q_ext);
   assign prev_in    = desired_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         desired_ff <= '0;
         prev_ff    <= '0;
         drive_ff   <= '0;
         halt_ff    <= 1'b0;
         len_ff     <= 1'b1;
      end else if (ctrl.commit) begin
         if (ctrl.tick) begin
            prev_ff  <= prev_in;
            drive_ff <= drive_in;
            halt_ff  <= halt_in;
            len_ff   <= len_in;
         end else begin
            desired_ff <= desired_in;
         end
      end
   end

   always_comb begin
      res.drive    = ctrl.tick ? drive_in : drive_ff;
      res.send     = ctrl.tick && send;
      res.at_limit = ctrl.tick && at_limit;
      res.status   = ctrl.tick && status;
   end

endmodule

/* src/pan_tilt_joint_limit_guard.sv */
// Top level of the two-axis pan/tilt velocity guard with soft joint limits.
//
// Each request transaction is either a speed command (req_func = 0) or a
// control tick (req_func = 1), and each produces exactly one response
// transaction. The block works on one transaction at a time. A command is
// accepted and captured, then holds the request side through a prepare state
// that finds the largest magnitude and forms each product |v| * speed_limit,
// the division state in the per-axis restoring dividers (one quotient bit
// per cycle), and a finish state that stores the result and registers the
// response. A tick is accepted and captured, then holds the request side
// through the finish state, which runs the per-axis limit test and decision
// tree and registers the response. While a finished response
// still waits in the output register with rsp_stall high, the next request
// is accepted and processed, but it holds in its finish state, with the
// request side stalled, until the output register frees up. Configuration
// registers may be written through the csr_ port at any time the block is
// idle; they take effect for the next transaction.
module pan_tilt_joint_limit_guard (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_func,
   input  logic signed [ptjlg_pkg::DATA_W-1:0]  req_desired_pan,
   input  logic signed [ptjlg_pkg::DATA_W-1:0]  req_desired_tilt,
   input  logic signed [ptjlg_pkg::DATA_W-1:0]  req_measured_pan,
   input  logic signed [ptjlg_pkg::DATA_W-1:0]  req_measured_tilt,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [ptjlg_pkg::DATA_W-1:0]  rsp_drive_pan,
   output logic signed [ptjlg_pkg::DATA_W-1:0]  rsp_drive_tilt,
   output logic                                 rsp_send_velocity,
   output logic                                 rsp_pan_at_limit,
   output logic                                 rsp_tilt_at_limit,
   output logic                                 rsp_pan_status,
   output logic                                 rsp_tilt_status,
   output logic                                 rsp_speed_scaled,
   input  logic                                 csr_we,
   input  logic [ptjlg_pkg::CSR_AW-1:0]         csr_addr,
   input  logic [ptjlg_pkg::LIMIT_W-1:0]        csr_wdata
);
   import ptjlg_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PREP = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Configuration registers.
   logic [LIMIT_W-1:0] pan_soft_ff, tilt_soft_ff, speed_lim_ff;

   // Captured request: the lanes only ever need one value per axis.
   logic                     func_ff;
   logic signed [DATA_W-1:0] pan_val_ff, tilt_val_ff;

   // Common divisor and scale flag, shared by both lanes.
   logic [DATA_W-1:0] m_ff, m_in, pan_mag, tilt_mag;
   logic              scaled_ff, scaled_in;

   lane_ctrl_type ctrl;
   lane_res_type  pan_res, tilt_res;

   logic req_take, rsp_free, fin_go;

   // Response payload and valid.
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] drive_pan_ff, drive_tilt_ff;
   logic                     send_ff, pan_lim_ff, tilt_lim_ff;
   logic                     pan_st_ff, tilt_st_ff, rsp_scaled_ff;

   assign req_stall = state_ff != S_IDLE;
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign fin_go    = (state_ff == S_FIN) && rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         pan_soft_ff  <= PAN_SOFT_LIMIT_RST;
         tilt_soft_ff <= TILT_SOFT_LIMIT_RST;
         speed_lim_ff <= SPEED_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_PAN_SOFT_LIMIT:  pan_soft_ff  <= csr_wdata;
            CSR_TILT_SOFT_LIMIT: tilt_soft_ff <= csr_wdata;
            CSR_SPEED_LIMIT:     speed_lim_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer: a tick goes straight to the finish state, a command first runs
   // the prepare state and the shared-count division in both lanes.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = (req_func == FUNC_TICK) ? S_FIN : S_PREP;
            end
         end
         S_PREP: begin
            state_in = S_DIV;
            cnt_in   = '0;
         end
         S_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QUO_W - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff     <= req_func;
         pan_val_ff  <= req_func ? req_measured_pan  : req_desired_pan;
         tilt_val_ff <= req_func ? req_measured_tilt : req_desired_tilt;
      end
   end

   // The divisor is the largest of speed_limit and both magnitudes, so the
   // scaled speeds never exceed speed_limit and keep their ratio.
   always_comb begin
      pan_mag   = mag(pan_val_ff);
      tilt_mag  = mag(tilt_val_ff);
      m_in      = DATA_W'(speed_lim_ff);
      if (pan_mag > m_in) begin
         m_in = pan_mag;
      end
      if (tilt_mag > m_in) begin
         m_in = tilt_mag;
      end
      scaled_in = m_in > DATA_W'(speed_lim_ff);
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_PREP) begin
         m_ff      <= m_in;
         scaled_ff <= scaled_in;
      end
   end

   always_comb begin
      ctrl.prep     = state_ff == S_PREP;
      ctrl.step     = state_ff == S_DIV;
      ctrl.commit   = fin_go;
      ctrl.tick     = func_ff == FUNC_TICK;
      ctrl.div_zero = m_ff == '0;
   end

   ptjlg_lane u_pan (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .value       (pan_val_ff),
      .soft_limit  (pan_soft_ff),
      .speed_limit (speed_lim_ff),
      .divisor     (m_ff),
      .res         (pan_res)
   );

   ptjlg_lane u_tilt (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .value       (tilt_val_ff),
      .soft_limit  (tilt_soft_ff),
      .speed_limit (speed_lim_ff),
      .divisor     (m_ff),
      .res         (tilt_res)
   );

   // Merge stage: the send flag is set when either lane asks to send its drive.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_go) begin
         drive_pan_ff  <= pan_res.drive;
         drive_tilt_ff <= tilt_res.drive;
         send_ff       <= pan_res.send || tilt_res.send;
         pan_lim_ff    <= pan_res.at_limit;
         tilt_lim_ff   <= tilt_res.at_limit;
         pan_st_ff     <= pan_res.status;
         tilt_st_ff    <= tilt_res.status;
         rsp_scaled_ff <= (func_ff == FUNC_COMMAND) && scaled_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive_pan     = drive_pan_ff;
   assign rsp_drive_tilt    = drive_tilt_ff;
   assign rsp_send_velocity = send_ff;
   assign rsp_pan_at_limit  = pan_lim_ff;
   assign rsp_tilt_at_limit = tilt_lim_ff;
   assign rsp_pan_status    = pan_st_ff;
   assign rsp_tilt_status   = tilt_st_ff;
   assign rsp_speed_scaled  = rsp_scaled_ff;

   // A new response only appears out of the finish state.
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_FIN)
      else $error("response raised outside the finish state");

   // The division never runs past the quotient width.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> cnt_ff < CNT_W'(QUO_W))
      else $error("division step count overrun");

   // A scaled command never reports tick results.
   a_scaled_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_speed_scaled |-> !rsp_send_velocity && !rsp_pan_at_limit)
      else $error("scaled command carries tick flags");

   // On a tick, pan can only be stopped at its limit, so a response with pan
   // stopped away from its limit is a command and carries no tick flags.
   a_stop_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pan_status && !rsp_pan_at_limit |->
         !rsp_send_velocity && !rsp_tilt_at_limit && !rsp_tilt_status)
      else $error("pan stopped away from its limit");

endmodule
